/* rtl/imh_pkg.sv */
// Shared types and constants of the indexed max-heap.
package imh_pkg;

   localparam int unsigned FIELD_BITS = 11;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DUP    = 2'd1,
      ST_ABSENT = 2'd2,
      ST_FULL   = 2'd3
   } imh_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_LAST,
      S_RISE,
      S_SINK,
      S_PLACE,
      S_REPLY
   } imh_state_type;

   typedef struct packed {
      logic                  opcode;
      logic [FIELD_BITS-1:0] key;
   } imh_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] top_key;
      logic [FIELD_BITS-1:0] count;
      imh_status_type        status;
   } imh_rsp_type;

endpackage

/* rtl/imh_ram.sv */
// Synchronous RAM with one write port and one registered read port.
module imh_ram #(
   parameter int unsigned ADDR_BITS = 11,
   parameter int unsigned DATA_BITS = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int unsigned DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/indexed_max_heap_core.sv */
// Indexed binary max-heap: heap slots and key position table in RAM, sequenced sift.
// A rejected beat, or a delete of the last slot, goes from the lookup straight to
// the result strobe; other beats sift level by level, then place their key.
// Throughput: one beat at a time; busy falls the cycle after the result strobe.
// Reset: the position table is swept to zero, one entry a cycle, with busy high;
// the result strobe cannot be stalled by the receiver.
module indexed_max_heap_core #(
   parameter int unsigned KEY_BITS = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  imh_pkg::imh_req_type req_data,
   output logic                 rsp_strobe,
   output imh_pkg::imh_rsp_type rsp_data
);

   import imh_pkg::*;

   localparam int unsigned KW = KEY_BITS;
   localparam logic [KW-1:0] CAPACITY = '1;
   localparam logic [KW-1:0] ROOT = KW'(1);

   // control and working registers
   imh_state_type  state_ff, state_in;
   logic [KW-1:0]  fill_ff, fill_in;
   logic [KW-1:0]  clr_ff, clr_in;
   logic           op_ff, op_in;
   logic [KW-1:0]  key_ff, key_in;
   logic [KW-1:0]  slot_ff, slot_in;     // current hole of the sift
   logic [KW-1:0]  cur_ff, cur_in;       // key travelling through the heap
   logic [KW-1:0]  top_ff, top_in;       // shadow of heap slot one
   imh_status_type status_ff, status_in;

   // memory ports
   logic          heap_wr_en;
   logic [KW-1:0] heap_wr_addr, heap_wr_data;
   logic [KW-1:0] heap_rd_a_addr, heap_rd_b_addr;
   logic [KW-1:0] heap_q_a, heap_q_b;
   logic          pos_wr_en;
   logic [KW-1:0] pos_wr_addr, pos_wr_data;
   logic [KW-1:0] pos_rd_addr, pos_q;

   // decode helpers
   logic [KW-1:0] req_key;
   logic          accept;
   logic          key_zero;
   logic          key_held;
   logic          full;
   logic          tail_hit;
   logic [KW-1:0] ins_slot;
   logic [KW-1:0] up_slot;
   logic          rise_more;
   logic          sink_down;
   logic [KW:0]   left_idx, right_idx, best_idx;
   logic [KW-1:0] best_key;
   logic          left_ok, right_ok;
   logic          sink_move;
   logic [KW:0]   next_left, next_right;

   assign req_key   = KW'(req_data.key);
   assign accept    = start && (state_ff == S_IDLE);
   assign key_zero  = (key_ff == '0);
   assign key_held  = (pos_q != '0);
   assign full      = (fill_ff == CAPACITY);
   assign tail_hit  = (pos_q == fill_ff);
   assign ins_slot  = fill_ff + ROOT;
   assign up_slot   = slot_ff >> 1;
   assign rise_more = (heap_q_a < cur_ff);
   assign sink_down = (key_ff > heap_q_a);

   // pick the larger child of the hole, if it beats the travelling key
   always_comb begin
      left_idx  = {slot_ff, 1'b0};
      right_idx = left_idx + (KW+1)'(1);
      left_ok   = (left_idx <= {1'b0, fill_ff});
      right_ok  = (right_idx <= {1'b0, fill_ff});
      best_idx  = {1'b0, slot_ff};
      best_key  = cur_ff;
      if (left_ok && (heap_q_a > best_key)) begin
         best_idx = left_idx;
         best_key = heap_q_a;
      end
      if (right_ok && (heap_q_b > best_key)) begin
         best_idx = right_idx;
         best_key = heap_q_b;
      end
      sink_move  = (best_idx != {1'b0, slot_ff});
      next_left  = {best_idx[KW-1:0], 1'b0};
      next_right = next_left + (KW+1)'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == CAPACITY) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            if (op_ff == OP_INSERT) begin
               if (key_zero || key_held || full) state_in = S_REPLY;
               else if (ins_slot > ROOT)         state_in = S_RISE;
               else                              state_in = S_PLACE;
            end else begin
               if (key_zero || !key_held || tail_hit) state_in = S_REPLY;
               else                                   state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (sink_down)            state_in = S_SINK;
            else if (slot_ff > ROOT)  state_in = S_RISE;
            else                      state_in = S_PLACE;
         end
         S_RISE: begin
            if (rise_more && (up_slot > ROOT)) state_in = S_RISE;
            else                               state_in = S_PLACE;
         end
         S_SINK: begin
            if (!sink_move) state_in = S_PLACE;
         end
         S_PLACE: state_in = S_REPLY;
         S_REPLY: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      fill_in        = fill_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      slot_in        = slot_ff;
      cur_in         = cur_ff;
      status_in      = status_ff;
      heap_wr_en     = 1'b0;
      heap_wr_addr   = slot_ff;
      heap_wr_data   = cur_ff;
      heap_rd_a_addr = up_slot;
      heap_rd_b_addr = up_slot;
      pos_wr_en      = 1'b0;
      pos_wr_addr    = cur_ff;
      pos_wr_data    = slot_ff;
      pos_rd_addr    = req_key;
      unique case (state_ff)
         S_CLEAR: begin
            pos_wr_en   = 1'b1;
            pos_wr_addr = clr_ff;
            pos_wr_data = '0;
            clr_in      = clr_ff + ROOT;
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_data.opcode;
               key_in = req_key;
            end
         end
         S_LOOKUP: begin
            status_in = ST_OK;
            if (op_ff == OP_INSERT) begin
               if (key_zero || key_held) begin
                  status_in = ST_DUP;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  // open a hole at the end, fetch its parent
                  fill_in        = ins_slot;
                  slot_in        = ins_slot;
                  cur_in         = key_ff;
                  heap_rd_a_addr = ins_slot >> 1;
               end
            end else begin
               if (key_zero || !key_held) begin
                  status_in = ST_ABSENT;
               end else begin
                  // drop the key from the table, fetch the last entry
                  pos_wr_en      = 1'b1;
                  pos_wr_addr    = key_ff;
                  pos_wr_data    = '0;
                  fill_in        = fill_ff - ROOT;
                  slot_in        = pos_q;
                  heap_rd_a_addr = fill_ff;
               end
            end
         end
         S_LAST: begin
            cur_in         = heap_q_a;
            heap_rd_a_addr = sink_down ? left_idx[KW-1:0] : up_slot;
            heap_rd_b_addr = right_idx[KW-1:0];
         end
         S_RISE: begin
            if (rise_more) begin
               // pull the parent down into the hole
               heap_wr_en     = 1'b1;
               heap_wr_data   = heap_q_a;
               pos_wr_en      = 1'b1;
               pos_wr_addr    = heap_q_a;
               slot_in        = up_slot;
               heap_rd_a_addr = up_slot >> 1;
            end
         end
         S_SINK: begin
            if (sink_move) begin
               // lift the larger child into the hole
               heap_wr_en     = 1'b1;
               heap_wr_data   = best_key;
               pos_wr_en      = 1'b1;
               pos_wr_addr    = best_key;
               slot_in        = best_idx[KW-1:0];
               heap_rd_a_addr = next_left[KW-1:0];
               heap_rd_b_addr = next_right[KW-1:0];
            end
         end
         S_PLACE: begin
            heap_wr_en = 1'b1;
            pos_wr_en  = 1'b1;
         end
         S_REPLY: begin
         end
      endcase
   end

   assign top_in = (heap_wr_en && (heap_wr_addr == ROOT)) ? heap_wr_data : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         fill_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      slot_ff   <= slot_in;
      cur_ff    <= cur_in;
      top_ff    <= top_in;
      status_ff <= status_in;
   end

   // heap slots: two copies written alike give two read ports for the child pair
   imh_ram #(.ADDR_BITS(KW), .DATA_BITS(KW)) u_heap_a (
      .clock   (clock),
      .wr_en   (heap_wr_en),
      .wr_addr (heap_wr_addr),
      .wr_data (heap_wr_data),
      .rd_addr (heap_rd_a_addr),
      .rd_data (heap_q_a)
   );

   imh_ram #(.ADDR_BITS(KW), .DATA_BITS(KW)) u_heap_b (
      .clock   (clock),
      .wr_en   (heap_wr_en),
      .wr_addr (heap_wr_addr),
      .wr_data (heap_wr_data),
      .rd_addr (heap_rd_b_addr),
      .rd_data (heap_q_b)
   );

   // key position table, zero meaning absent
   imh_ram #(.ADDR_BITS(KW), .DATA_BITS(KW)) u_pos (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (pos_wr_addr),
      .wr_data (pos_wr_data),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_q)
   );

   // result beat, shown for one cycle
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_REPLY);
   assign rsp_data.top_key = (fill_ff != '0) ? FIELD_BITS'(top_ff) : '0;
   assign rsp_data.count   = FIELD_BITS'(fill_ff);
   assign rsp_data.status  = status_ff;

   a_accept_lookup : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_LOOKUP))
      else $error("accepted beat did not start a lookup");

   a_reply_frees : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("block still busy after result beat");

   a_sink_in_heap : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SINK) |-> ((slot_ff != '0) && (slot_ff <= fill_ff)))
      else $error("sift-down hole outside the heap");

   a_rise_above_root : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RISE) |-> (slot_ff > ROOT))
      else $error("sift-up from the root");

   a_no_slot_zero : assert property (@(posedge clock) disable iff (reset)
      heap_wr_en |-> (heap_wr_addr != '0))
      else $error("heap write to slot zero");

endmodule

/* verif/imh_check_pkg.sv */
`timescale 1ns / 100ps
// Heap mirror for the indexed max-heap testbench: predicts and checks every reply beat.
package imh_check_pkg;

   import imh_pkg::*;

   localparam int unsigned KEY_SPAN = 1 << FIELD_BITS;
   localparam int unsigned CAPACITY = KEY_SPAN - 1;

   typedef logic [FIELD_BITS-1:0] key_word_type;

   class heap_mirror;
      key_word_type   slot_key [KEY_SPAN];
      int unsigned    key_slot [KEY_SPAN];
      int unsigned    fill;
      imh_rsp_type    awaited_replies [$];
      int unsigned    fault_count;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i] = '0;
            key_slot[i] = 0;
         end
         fill = 0;
         fault_count = 0;
      endfunction

      function void put(int unsigned slot, key_word_type k);
         slot_key[slot] = k;
         key_slot[k] = slot;
      endfunction

      // Walk towards the root while the parent is smaller.
      function void rise(int unsigned slot, key_word_type k);
         while (slot > 1 && slot_key[slot >> 1] < k) begin
            put(slot, slot_key[slot >> 1]);
            slot = slot >> 1;
         end
         put(slot, k);
      endfunction

      // Apply one accepted request beat and queue the reply it must give.
      function void note_beat(imh_req_type beat);
         key_word_type   k;
         key_word_type   moved;
         key_word_type   a;
         int unsigned    slot;
         int unsigned    best;
         int unsigned    child;
         bit             sinking;
         imh_status_type verdict;
         imh_rsp_type    reply;
         k = beat.key;
         if (beat.opcode == OP_INSERT) begin
            if (k == 0 || key_slot[k] != 0) begin
               verdict = ST_DUP;
            end else if (fill >= CAPACITY) begin
               verdict = ST_FULL;
            end else begin
               verdict = ST_OK;
               fill++;
               rise(fill, k);
            end
         end else begin
            if (k == 0 || key_slot[k] == 0) begin
               verdict = ST_ABSENT;
            end else begin
               verdict = ST_OK;
               slot = key_slot[k];
               key_slot[k] = 0;
               if (slot == fill) begin
                  fill--;
               end else begin
                  moved = slot_key[fill];
                  fill--;
                  put(slot, moved);
                  if (k > moved) begin
                     sinking = 1'b1;
                     while (sinking) begin
                        best = slot;
                        child = slot << 1;
                        if (child <= fill && slot_key[child] > slot_key[best])
                           best = child;
                        if (child + 1 <= fill && slot_key[child + 1] > slot_key[best])
                           best = child + 1;
                        if (best == slot) begin
                           sinking = 1'b0;
                        end else begin
                           a = slot_key[slot];
                           put(slot, slot_key[best]);
                           put(best, a);
                           slot = best;
                        end
                     end
                  end else begin
                     rise(slot, moved);
                  end
               end
            end
         end
         reply.top_key = (fill != 0) ? slot_key[1] : '0;
         reply.count   = FIELD_BITS'(fill);
         reply.status  = verdict;
         awaited_replies.insert(awaited_replies.size(), reply);
      endfunction

      function void check_reply(imh_rsp_type got);
         imh_rsp_type want;
         if (awaited_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("reply beat with none awaited: top %0d count %0d status %0d",
                        got.top_key, got.count, got.status);
            return;
         end
         want = awaited_replies.pop_front();
         if (got.top_key !== want.top_key || got.count !== want.count ||
             got.status !== want.status) begin
            fault_count++;
            if (fault_count <= 10)
               $display("mismatch: exp top %0d cnt %0d st %0d, got top %0d cnt %0d st %0d",
                        want.top_key, want.count, want.status,
                        got.top_key, got.count, got.status);
         end
      endfunction

      function int unsigned pending();
         return awaited_replies.size();
      endfunction
   endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Top of the indexed max-heap testbench: clock, reset, stimulus, reply checking and watchdog.
module tb_top;

   import imh_pkg::*;
   import imh_check_pkg::*;

   // Longest stretch with neither a request nor a reply beat: covers the
   // position-table sweep after reset with a wide margin.
   localparam int unsigned QUIET_LIMIT  = 10000;
   localparam int unsigned RANDOM_BEATS = 790;
   // Settle time after the last reply, before the verdict is printed.
   localparam int unsigned TAIL_CYCLES  = 20;

   logic        clock;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   imh_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   imh_rsp_type rsp_data;

   heap_mirror  mirror = new();

   // Keys the stimulus believes are held, with a reverse index (slot + 1, 0 = absent).
   int unsigned held_list [$];
   int unsigned held_at [KEY_SPAN];
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;

   indexed_max_heap_core #(
      .KEY_BITS(FIELD_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Note each accepted request beat, check each reply beat, and watch for a hang.
   // Everything here samples values from before the edge, so ordering is safe.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         mirror.note_beat(req_data);
      if (!reset && rsp_strobe)
         mirror.check_reply(rsp_data);
      if ((start && !busy) || rsp_strobe)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Pick a key not held at the moment (never called with a full heap).
   function automatic key_word_type fresh_key();
      int unsigned k;
      k = $urandom_range(1, CAPACITY);
      while (held_at[k] != 0)
         k = $urandom_range(1, CAPACITY);
      return key_word_type'(k);
   endfunction

   function automatic key_word_type held_key();
      return key_word_type'(held_list[$urandom_range(0, held_list.size() - 1)]);
   endfunction

   // Idle the sender between bursts; some bursts run long with no gaps at all.
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 24);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Present one beat and hold it until the block takes it. Start stays high
   // afterwards unless pace drops it, so back-to-back beats never toggle it.
   task automatic issue(input logic op, input key_word_type key);
      imh_req_type beat;
      int unsigned idx;
      int unsigned last;
      beat.opcode = op;
      beat.key    = key;
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      // Track which keys are held so later beats can be well formed.
      if (op == OP_INSERT && key != 0 && held_at[key] == 0 && held_list.size() < CAPACITY) begin
         held_list.insert(held_list.size(), 32'(key));
         held_at[key] = held_list.size();
      end else if (op == OP_DELETE && key != 0 && held_at[key] != 0) begin
         idx  = held_at[key] - 1;
         last = held_list[held_list.size() - 1];
         held_list[idx] = last;
         held_at[last]  = idx + 1;
         held_list.pop_back();
         held_at[key] = 0;
      end
      pace();
   endtask

   // Hold the sender off until every reply owed has come back.
   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned n;
      int unsigned r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty heap, key zero both ways, extreme and alternating keys,
      // duplicates, absent deletes, root and last-slot deletes, sink and rise.
      issue(OP_DELETE, 11'd5);
      issue(OP_DELETE, 11'd0);
      issue(OP_INSERT, 11'd0);
      issue(OP_INSERT, 11'd2047);
      issue(OP_INSERT, 11'd2047);
      issue(OP_INSERT, 11'd1);
      issue(OP_INSERT, 11'h555);
      issue(OP_INSERT, 11'h2AA);
      issue(OP_INSERT, 11'h400);
      issue(OP_INSERT, 11'h3FF);
      issue(OP_INSERT, 11'd2);
      issue(OP_DELETE, 11'd2047);
      issue(OP_DELETE, 11'd2);
      issue(OP_DELETE, 11'd3);
      issue(OP_DELETE, 11'h2AA);
      issue(OP_INSERT, 11'd2046);
      issue(OP_DELETE, 11'd1);
      issue(OP_DELETE, 11'd0);
      issue(OP_DELETE, 11'h555);
      issue(OP_DELETE, 11'h400);
      issue(OP_DELETE, 11'h3FF);
      issue(OP_DELETE, 11'd2046);
      issue(OP_INSERT, 11'd0);

      // Random: mostly valid inserts and deletes, with some rejects mixed in.
      for (n = 0; n < RANDOM_BEATS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            issue(($urandom_range(0, 1) != 0) ? OP_DELETE : OP_INSERT, '0);
         else if (r < 10 && held_list.size() != 0)
            issue(OP_INSERT, held_key());
         else if (r < 15)
            issue(OP_DELETE, fresh_key());
         else if (held_list.size() == 0 || r < ((held_list.size() < 300) ? 65 : 45))
            issue(OP_INSERT, fresh_key());
         else
            issue(OP_DELETE, held_key());
      end

      hold_until_drained();

      // Drain to empty in random order, with the odd insert on the way down.
      while (held_list.size() != 0) begin
         if (held_list.size() < CAPACITY && $urandom_range(0, 9) == 0)
            issue(OP_INSERT, fresh_key());
         else
            issue(OP_DELETE, held_key());
      end
      issue(OP_DELETE, 11'd1);
      issue(OP_INSERT, 11'd0);

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mirror.fault_count == 0 && mirror.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/indexed_max_heap_core.sv
verif/imh_check_pkg.sv
verif/tb_top.sv
